### sv/ils_pkg.sv
`timescale 1ns / 1ps
// ils_pkg: shared types and constants for the indexed list store.
// Used by ils_cell, indexed_list_store_unit and ils_checker. No dependencies.
package ils_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // index width covers the largest supported capacity (1024) plus one
    localparam int IDX_W   = 11;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int PORT_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT_AT   = 3'd0,
        CMD_APPEND      = 3'd1,
        CMD_REMOVE_AT   = 3'd2,
        CMD_REMOVE_LAST = 3'd3,
        CMD_READ        = 3'd4,
        CMD_WRITE       = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_WRITE  = 2'd3
    } t_shift_op;

    // broadcast from the control to every cell
    typedef struct packed {
        logic             load;
        t_shift_op        op;
        logic [IDX_W-1:0] pos;
        logic             rd;
        logic [IDX_W-1:0] sel;
    } t_cell_ctrl;

endpackage

### sv/ils_cell.sv
`timescale 1ns / 1ps
// ils_cell: one list slot. Holds an entry, shifts with its neighbours
// and captures its entry as a read tap. Depends on ils_pkg.
module ils_cell #(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  ils_pkg::t_cell_ctrl    i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_data,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [VALUE_WIDTH-1:0] o_tap
);
    import ils_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic [VALUE_WIDTH-1:0] r_tap;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (MY_IDX > i_ctrl.pos) begin
                    n_value = i_left;
                end else if (MY_IDX == i_ctrl.pos) begin
                    n_value = i_data;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= i_ctrl.pos) begin
                    n_value = i_right;
                end
            end
            OP_WRITE: begin
                if (MY_IDX == i_ctrl.pos) begin
                    n_value = i_data;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctrl.load) begin
            r_tap <= (i_ctrl.rd && (MY_IDX == i_ctrl.sel)) ? r_value : '0;
        end
    end

    assign o_value = r_value;
    assign o_tap   = r_tap;

endmodule

### sv/indexed_list_store_unit.sv
// Indexed list store: cell read taps and a status/count register feed the
// output register. One transaction per cycle unless the output stalls; every
// cell shifts in the accept cycle and registers its read tap, and the taps
// are OR-reduced into the output register. Reset (i_rst_n low, synchronous)
// empties the list and drops pending results; entry contents are not cleared.
`timescale 1ns / 1ps
module indexed_list_store_unit #(
    parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ils_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ils_pkg::POS_W-1:0]   i_position,
    input  logic signed [ils_pkg::PORT_W-1:0] i_item_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [ils_pkg::PORT_W-1:0] o_result_value,
    output logic [ils_pkg::STAT_W-1:0]  o_status,
    output logic [ils_pkg::COUNT_W-1:0] o_entry_count
);
    import ils_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int XW    = (VALUE_WIDTH > PORT_W) ? VALUE_WIDTH : PORT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                   w_accept;
    logic                   w_b_load;
    t_cell_ctrl             w_ctrl;
    t_status                w_status;
    logic [CNT_W-1:0]       n_occ;
    logic [IDX_W-1:0]       w_pos;
    logic [IDX_W-1:0]       w_occ;
    logic [XW-1:0]          w_item_ext;
    logic [VALUE_WIDTH-1:0] w_data;
    logic [VALUE_WIDTH-1:0] w_reduced;
    logic [XW-1:0]          w_res_ext;

    logic [VALUE_WIDTH-1:0] w_value [CAPACITY];
    logic [VALUE_WIDTH-1:0] w_tap   [CAPACITY];

    logic [CNT_W-1:0]       r_occ;
    logic                   r_a_vld;
    t_status                r_a_status;
    logic [CNT_W-1:0]       r_a_count;
    logic                   r_out_vld;
    logic [PORT_W-1:0]      r_out_value;
    t_status                r_out_status;
    logic [COUNT_W-1:0]     r_out_count;
    logic [IDX_W-1:0]       w_count_ext;

    assign w_b_load   = r_a_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_a_vld || w_b_load;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_pos      = IDX_W'(i_position);
    assign w_occ      = IDX_W'(r_occ);
    assign w_item_ext = XW'($unsigned(i_item_value));
    assign w_data     = w_item_ext[VALUE_WIDTH-1:0];

    always_comb begin
        w_ctrl.load = w_accept;
        w_ctrl.op   = OP_NONE;
        w_ctrl.pos  = w_pos;
        w_ctrl.rd   = 1'b0;
        w_ctrl.sel  = w_pos;
        w_status    = ST_OK;
        n_occ       = r_occ;
        unique case (t_cmd'(i_cmd))
            CMD_INSERT_AT: begin
                if (w_pos > w_occ) begin
                    w_status = ST_RANGE;
                end else if (r_occ == CAP_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.op = OP_INSERT;
                    n_occ     = r_occ + CNT_W'(1);
                end
            end
            CMD_APPEND: begin
                if (r_occ == CAP_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.op  = OP_INSERT;
                    w_ctrl.pos = w_occ;
                    n_occ      = r_occ + CNT_W'(1);
                end
            end
            CMD_REMOVE_AT: begin
                if (w_pos >= w_occ) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.op = OP_REMOVE;
                    w_ctrl.rd = 1'b1;
                    n_occ     = r_occ - CNT_W'(1);
                end
            end
            CMD_REMOVE_LAST: begin
                if (r_occ == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.rd  = 1'b1;
                    w_ctrl.sel = w_occ - IDX_W'(1);
                    n_occ      = r_occ - CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (w_pos >= w_occ) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.rd = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (w_pos >= w_occ) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.op = OP_WRITE;
                    w_ctrl.rd = 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_ctrl.op = OP_NONE;
            n_occ     = r_occ;
        end
    end

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;
        if (c == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_value[c-1];
        end
        if (c == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_value[c+1];
        end
        ils_cell #(
            .INDEX       (c),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_data  (w_data),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[c]),
            .o_tap   (w_tap[c])
        );
    end

    // only the selected cell's tap is non-zero
    always_comb begin
        w_reduced = '0;
        for (int c = 0; c < CAPACITY; c++) begin
            w_reduced = w_reduced | w_tap[c];
        end
    end

    assign w_res_ext   = XW'(w_reduced);
    assign w_count_ext = IDX_W'(r_a_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (w_accept) begin
                r_a_vld <= 1'b1;
            end else if (w_b_load) begin
                r_a_vld <= 1'b0;
            end
            if (w_b_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_status <= w_status;
            r_a_count  <= n_occ;
        end
        if (w_b_load) begin
            r_out_value  <= w_res_ext[PORT_W-1:0];
            r_out_status <= r_a_status;
            r_out_count  <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;

endmodule

### sv/ils_checker.sv
`timescale 1ns / 1ps
// ils_checker: port-level checks for indexed_list_store_unit, bound to it below.
// Depends on ils_pkg.
module ils_checker #(
    parameter int CAPACITY    = ils_pkg::CAPACITY_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic signed [ils_pkg::PORT_W-1:0] o_result_value,
    input logic [ils_pkg::STAT_W-1:0]  o_status,
    input logic [ils_pkg::COUNT_W-1:0] o_entry_count
);
    import ils_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_LO = COUNT_W'(CAPACITY);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_value)
            && $stable(o_status) && $stable(o_entry_count))
        else $error("result changed while stalled");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_entry_count == CAP_LO
            && o_result_value == '0)
        else $error("full status with wrong count or value");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> o_entry_count == '0
            && o_result_value == '0)
        else $error("empty status with entries or value");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_RANGE) |-> o_result_value == '0)
        else $error("refused transaction returned a value");

endmodule

bind indexed_list_store_unit ils_checker #(
    .CAPACITY    (CAPACITY)
) u_ils_checker (.*);
